// ===== hdl/tlca_pkg.sv =====
// ----------------------------------------------------------------------------
// Tree ancestor / LCA engine package
// Sizes, beat payload types and the layout of one row of the node memory.
// ----------------------------------------------------------------------------
package tlca_pkg;

   localparam int NODES    = 1024;
   localparam int LEVELS   = 11;
   localparam int NODE_W   = $clog2(NODES);
   localparam int LVL_W    = $clog2(LEVELS);
   localparam int STEP_W   = 11;
   localparam int WEIGHT_W = 16;
   localparam int DIST_W   = 27;
   localparam int DEPTH_W  = 32;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_KTH    = 2'd1,
      OP_LCA    = 2'd2,
      OP_DIST   = 2'd3
   } opcode_type;

   typedef struct packed {
      opcode_type            opcode;
      logic [NODE_W-1:0]     node_a;
      logic [NODE_W-1:0]     node_b;
      logic [STEP_W-1:0]     step_count;
      logic [WEIGHT_W-1:0]   edge_weight;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0]     result_node;
      logic                  found;
      logic [DIST_W-1:0]     path_length;
   } rsp_type;

   // One ancestor entry; an invalid entry is always stored as all zero.
   typedef struct packed {
      logic                  valid;
      logic [NODE_W-1:0]     node;
   } anc_entry_type;

   typedef struct packed {
      anc_entry_type [LEVELS-1:0] anc;
      logic [DEPTH_W-1:0]         depth;
      logic [DIST_W-1:0]          root_dist;
   } node_row_type;

   localparam int ROW_W = $bits(node_row_type);

endpackage

// ===== hdl/tlca_ram.sv =====
// ----------------------------------------------------------------------------
// Tree ancestor / LCA engine node memory
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module tlca_ram #(
   parameter int DATA_W = 8,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr_a,
   output logic [DATA_W-1:0] rd_data_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_a_ff;
   logic [DATA_W-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

// ===== hdl/tree_ancestor_lca_engine_top.sv =====
// ----------------------------------------------------------------------------
// Tree ancestor / LCA engine
// Binary-lifting ancestor table with depth and weighted root distance per
// node, all kept in one row-per-node memory. Insert, k-th ancestor, lowest
// common ancestor and distance, weighted or unit per the csr mode.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_data (req_type)
//   rsp      out        rsp_valid / rsp_ready  rsp_data (rsp_type)
//   csr      in         csr_valid / csr_ready  csr_data (weighted mode)
//
// One operation is in flight at a time; the memory walk sets the time.
// LCA and distance use one memory read per level for the depth climb and
// one dual read per level for the joint lift. After reset a clearing pass
// writes all NODES rows, one row a cycle, before req_ready rises. A stalled
// rsp beat holds the next result in its final state and so also blocks the
// accept of the following request.
// ----------------------------------------------------------------------------
module tree_ancestor_lca_engine_top
   import tlca_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic    csr_data
);

   typedef enum logic [9:0] {
      S_CLEAR = 10'b0000000001,
      S_IDLE  = 10'b0000000010,
      S_START = 10'b0000000100,
      S_INS   = 10'b0000001000,
      S_CLIMB = 10'b0000010000,
      S_EQ    = 10'b0000100000,
      S_LIFT  = 10'b0001000000,
      S_FINAL = 10'b0010000000,
      S_DIST  = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   state_type            state_ff, state_in;
   logic [NODE_W-1:0]    clear_idx_ff, clear_idx_in;
   logic [LVL_W-1:0]     lvl_ff, lvl_in;
   req_type              req_ff, req_in;
   logic [NODE_W-1:0]    u_ff, u_in;
   logic [NODE_W-1:0]    v_ff, v_in;
   logic [LEVELS-1:0]    climb_k_ff, climb_k_in;
   logic                 climb_v_ff, climb_v_in;
   node_row_type         build_ff, build_in;
   anc_entry_type        prev_ff, prev_in;
   logic [DIST_W-1:0]    da_ff, da_in;
   logic [DIST_W-1:0]    db_ff, db_in;
   rsp_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic                 weighted_mode_ff, weighted_mode_in;

   logic                 mem_we;
   logic [NODE_W-1:0]    mem_waddr;
   node_row_type         mem_wdata;
   logic [NODE_W-1:0]    rd_addr_a;
   logic [NODE_W-1:0]    rd_addr_b;
   node_row_type         q_a;
   node_row_type         q_b;

   logic                 depth_a_gt;
   logic [DEPTH_W-1:0]   depth_diff;
   logic [NODE_W-1:0]    climb_cur;
   anc_entry_type        climb_entry;
   logic [NODE_W-1:0]    climb_next;
   anc_entry_type        lift_u;
   anc_entry_type        lift_v;
   logic                 lift_take;
   anc_entry_type        ins_src;
   anc_entry_type        ins_entry;

   tlca_ram #(
      .DATA_W (ROW_W),
      .ADDR_W (NODE_W)
   ) u_ram (
      .clock     (clock),
      .wr_en     (mem_we),
      .wr_addr   (mem_waddr),
      .wr_data   (mem_wdata),
      .rd_addr_a (rd_addr_a),
      .rd_data_a (q_a),
      .rd_addr_b (rd_addr_b),
      .rd_data_b (q_b)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign depth_a_gt = q_a.depth > q_b.depth;
   assign depth_diff = depth_a_gt ? (q_a.depth - q_b.depth) : (q_b.depth - q_a.depth);

   assign climb_cur   = climb_v_ff ? v_ff : u_ff;
   assign climb_entry = q_a.anc[lvl_ff];
   assign climb_next  = climb_k_ff[lvl_ff] ? climb_entry.node : climb_cur;

   assign lift_u    = q_a.anc[lvl_ff];
   assign lift_v    = q_b.anc[lvl_ff];
   assign lift_take = lift_u.valid && lift_v.valid && (lift_u != lift_v);

   // When the previous level points back at the node being written, its row
   // in memory is stale; take the entry just built instead.
   assign ins_src   = q_a.anc[lvl_ff - LVL_W'(1)];
   always_comb begin
      if (!prev_ff.valid) begin
         ins_entry = '0;
      end else if (prev_ff.node == req_ff.node_a) begin
         ins_entry = prev_ff;
      end else if (ins_src.valid) begin
         ins_entry = ins_src;
      end else begin
         ins_entry = '0;
      end
   end

   always_comb begin
      state_in         = state_ff;
      clear_idx_in     = clear_idx_ff;
      lvl_in           = lvl_ff;
      req_in           = req_ff;
      u_in             = u_ff;
      v_in             = v_ff;
      climb_k_in       = climb_k_ff;
      climb_v_in       = climb_v_ff;
      build_in         = build_ff;
      prev_in          = prev_ff;
      da_in            = da_ff;
      db_in            = db_ff;
      res_in           = res_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_data_in      = rsp_data_ff;
      weighted_mode_in = weighted_mode_ff;
      mem_we           = 1'b0;
      mem_waddr        = req_ff.node_a;
      mem_wdata        = build_ff;
      rd_addr_a        = u_ff;
      rd_addr_b        = v_ff;

      if (csr_valid) begin
         weighted_mode_in = csr_data;
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_we       = 1'b1;
            mem_waddr    = clear_idx_ff;
            mem_wdata    = '0;
            clear_idx_in = clear_idx_ff + NODE_W'(1);
            if (clear_idx_ff == NODE_W'(NODES - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               req_in    = req_data;
               rd_addr_a = (req_data.opcode == OP_INSERT) ? req_data.node_b
                                                          : req_data.node_a;
               rd_addr_b = req_data.node_b;
               state_in  = S_START;
            end
         end

         S_START: begin
            res_in = '0;
            unique case (req_ff.opcode)
               OP_INSERT: begin
                  if (req_ff.node_a == '0) begin
                     state_in = S_DONE;
                  end else begin
                     build_in            = '0;
                     build_in.depth      = q_a.depth + DEPTH_W'(1);
                     build_in.root_dist  = q_a.root_dist + (weighted_mode_ff ?
                                           DIST_W'(req_ff.edge_weight) : DIST_W'(1));
                     build_in.anc[0].valid = 1'b1;
                     build_in.anc[0].node  = req_ff.node_b;
                     prev_in.valid       = 1'b1;
                     prev_in.node        = req_ff.node_b;
                     lvl_in              = LVL_W'(1);
                     rd_addr_a           = req_ff.node_b;
                     state_in            = S_INS;
                  end
               end
               OP_KTH: begin
                  if ((req_ff.step_count >> LEVELS) != '0) begin
                     state_in = S_DONE;
                  end else begin
                     u_in       = req_ff.node_a;
                     climb_v_in = 1'b0;
                     climb_k_in = LEVELS'(req_ff.step_count);
                     lvl_in     = LVL_W'(LEVELS - 1);
                     rd_addr_a  = req_ff.node_a;
                     state_in   = S_CLIMB;
                  end
               end
               OP_LCA, OP_DIST: begin
                  u_in       = req_ff.node_a;
                  v_in       = req_ff.node_b;
                  da_in      = q_a.root_dist;
                  db_in      = q_b.root_dist;
                  climb_v_in = !depth_a_gt;
                  if (depth_diff == '0) begin
                     state_in = S_EQ;
                  end else if ((depth_diff >> LEVELS) != '0) begin
                     state_in = S_DONE;
                  end else begin
                     climb_k_in = LEVELS'(depth_diff);
                     lvl_in     = LVL_W'(LEVELS - 1);
                     rd_addr_a  = depth_a_gt ? req_ff.node_a : req_ff.node_b;
                     state_in   = S_CLIMB;
                  end
               end
            endcase
         end

         S_INS: begin
            build_in.anc[lvl_ff] = ins_entry;
            prev_in              = ins_entry;
            rd_addr_a            = ins_entry.node;
            if (lvl_ff == LVL_W'(LEVELS - 1)) begin
               mem_we       = 1'b1;
               mem_waddr    = req_ff.node_a;
               mem_wdata    = build_in;
               res_in.found = 1'b1;
               state_in     = S_DONE;
            end else begin
               lvl_in = lvl_ff + LVL_W'(1);
            end
         end

         S_CLIMB: begin
            if (climb_k_ff[lvl_ff] && !climb_entry.valid) begin
               state_in = S_DONE;
            end else begin
               if (climb_v_ff) begin
                  v_in = climb_next;
               end else begin
                  u_in = climb_next;
               end
               rd_addr_a = climb_next;
               if (lvl_ff == '0) begin
                  if (req_ff.opcode == OP_KTH) begin
                     res_in.found       = 1'b1;
                     res_in.result_node = climb_next;
                     state_in           = S_DONE;
                  end else begin
                     state_in = S_EQ;
                  end
               end else begin
                  lvl_in = lvl_ff - LVL_W'(1);
               end
            end
         end

         S_EQ: begin
            if (u_ff == v_ff) begin
               if (req_ff.opcode == OP_LCA) begin
                  res_in.found       = 1'b1;
                  res_in.result_node = u_ff;
                  state_in           = S_DONE;
               end else begin
                  rd_addr_a = u_ff;
                  state_in  = S_DIST;
               end
            end else begin
               lvl_in    = LVL_W'(LEVELS - 1);
               rd_addr_a = u_ff;
               rd_addr_b = v_ff;
               state_in  = S_LIFT;
            end
         end

         S_LIFT: begin
            if (lift_take) begin
               u_in      = lift_u.node;
               v_in      = lift_v.node;
               rd_addr_a = lift_u.node;
               rd_addr_b = lift_v.node;
            end
            if (lvl_ff == '0) begin
               state_in = S_FINAL;
            end else begin
               lvl_in = lvl_ff - LVL_W'(1);
            end
         end

         S_FINAL: begin
            if (!q_a.anc[0].valid || (q_a.anc[0] != q_b.anc[0])) begin
               state_in = S_DONE;
            end else if (req_ff.opcode == OP_LCA) begin
               res_in.found       = 1'b1;
               res_in.result_node = q_a.anc[0].node;
               state_in           = S_DONE;
            end else begin
               rd_addr_a = q_a.anc[0].node;
               state_in  = S_DIST;
            end
         end

         S_DIST: begin
            res_in.found       = 1'b1;
            res_in.path_length = DIST_W'(da_ff + db_ff - {q_a.root_dist[DIST_W-2:0], 1'b0});
            state_in           = S_DONE;
         end

         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_CLEAR;
         clear_idx_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
         weighted_mode_ff <= 1'b0;
      end else begin
         state_ff         <= state_in;
         clear_idx_ff     <= clear_idx_in;
         rsp_valid_ff     <= rsp_valid_in;
         weighted_mode_ff <= weighted_mode_in;
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff      <= lvl_in;
      req_ff      <= req_in;
      u_ff        <= u_in;
      v_ff        <= v_in;
      climb_k_ff  <= climb_k_in;
      climb_v_ff  <= climb_v_in;
      build_ff    <= build_in;
      prev_ff     <= prev_in;
      da_ff       <= da_in;
      db_ff       <= db_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // An accepted beat always moves on to the dispatch state.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_START))
      else $error("accepted request did not enter dispatch");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == S_CLEAR || state_ff == S_INS))
      else $error("node memory written outside clear or insert");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result beat raised outside the completion state");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_INS || state_ff == S_CLIMB || state_ff == S_LIFT)
         |-> (lvl_ff <= LVL_W'(LEVELS - 1)))
      else $error("level counter out of range during a walk");

   a_insert_no_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && req_ff.opcode == OP_INSERT) |-> (res_ff.path_length == '0))
      else $error("insert produced a nonzero path length");

endmodule

// ===== verif/tree_ancestor_lca_engine_top_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tree ancestor / LCA engine testbench
// Drives insert, k-th ancestor, LCA and distance requests into the engine,
// keeps its own copy of the ancestor, depth and root-distance tables, and
// checks every response beat field by field against the predicted one. A
// short directed sequence is followed by random tree-building traffic under
// three sender/receiver stall profiles and both weight modes.
// ----------------------------------------------------------------------------
module tree_ancestor_lca_engine_top_test
   import tlca_pkg::*;
();

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 2 * LEVELS + 8;
   localparam int MAX_STEP     = (1 << STEP_W) - 1;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic    csr_data  = 1'b0;

   // Shadow copy of the engine state.
   anc_entry_type       anc_tab [NODES][LEVELS];
   logic [DEPTH_W-1:0]  depth_tab [NODES];
   logic [DIST_W-1:0]   root_dist_tab [NODES];
   logic                weighted = 1'b0;

   // Bookkeeping for stimulus shaping.
   logic                node_present [NODES];
   logic [NODE_W-1:0]   present_list [$];
   logic [NODE_W-1:0]   last_inserted = '0;

   rsp_type             pending_rsp_q [$];
   int                  fail_count  = 0;
   int unsigned         cycle_count = 0;
   int                  send_idle_pct = 0;
   int                  recv_idle_pct = 0;

   tree_ancestor_lca_engine_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------
   function automatic logic climb_up(input logic [NODE_W-1:0] start,
                                     input logic [DEPTH_W-1:0] steps,
                                     output logic [NODE_W-1:0] reached);
      logic [NODE_W-1:0] cur;
      cur     = start;
      reached = '0;
      if ((steps >> LEVELS) != 0) return 1'b0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (steps[i]) begin
            if (!anc_tab[cur][i].valid) return 1'b0;
            cur = anc_tab[cur][i].node;
         end
      end
      reached = cur;
      return 1'b1;
   endfunction

   function automatic logic common_ancestor(input logic [NODE_W-1:0] a,
                                            input logic [NODE_W-1:0] b,
                                            output logic [NODE_W-1:0] meet);
      logic [NODE_W-1:0]  u;
      logic [NODE_W-1:0]  v;
      logic [DEPTH_W-1:0] du;
      logic [DEPTH_W-1:0] dv;
      anc_entry_type      eu;
      anc_entry_type      ev;
      u    = a;
      v    = b;
      du   = depth_tab[a];
      dv   = depth_tab[b];
      meet = '0;
      if (du > dv) begin
         if (!climb_up(a, du - dv, u)) return 1'b0;
      end else if (dv > du) begin
         if (!climb_up(b, dv - du, v)) return 1'b0;
      end
      if (u == v) begin
         meet = u;
         return 1'b1;
      end
      for (int i = LEVELS - 1; i >= 0; i--) begin
         eu = anc_tab[u][i];
         ev = anc_tab[v][i];
         if (eu.valid && ev.valid && eu != ev) begin
            u = eu.node;
            v = ev.node;
         end
      end
      eu = anc_tab[u][0];
      ev = anc_tab[v][0];
      if (!eu.valid || eu != ev) return 1'b0;
      meet = eu.node;
      return 1'b1;
   endfunction

   function automatic logic insert_node(input logic [NODE_W-1:0] child,
                                        input logic [NODE_W-1:0] parent,
                                        input logic [WEIGHT_W-1:0] weight);
      anc_entry_type prev;
      anc_entry_type nxt;
      logic          live;
      if (child == '0) return 1'b0;
      depth_tab[child]     = depth_tab[parent] + 1;
      root_dist_tab[child] = root_dist_tab[parent]
                             + (weighted ? DIST_W'(weight) : DIST_W'(1));
      anc_tab[child][0].valid = 1'b1;
      anc_tab[child][0].node  = parent;
      live = 1'b1;
      // Rows are updated in place, so a node hung under itself sees its own
      // fresh lower levels while the upper ones are filled.
      for (int i = 1; i < LEVELS; i++) begin
         prev = anc_tab[child][i-1];
         nxt  = '0;
         if (live && prev.valid) nxt = anc_tab[prev.node][i-1];
         if (!nxt.valid) begin
            live = 1'b0;
            nxt  = '0;
         end
         anc_tab[child][i] = nxt;
      end
      return 1'b1;
   endfunction

   function automatic rsp_type apply_request(input req_type r);
      rsp_type           rsp;
      logic [NODE_W-1:0] hit;
      rsp = '0;
      hit = '0;
      case (r.opcode)
         OP_INSERT: begin
            rsp.found = insert_node(r.node_a, r.node_b, r.edge_weight);
         end
         OP_KTH: begin
            if (climb_up(r.node_a, DEPTH_W'(r.step_count), hit)) begin
               rsp.found       = 1'b1;
               rsp.result_node = hit;
            end
         end
         OP_LCA, OP_DIST: begin
            if (common_ancestor(r.node_a, r.node_b, hit)) begin
               rsp.found = 1'b1;
               if (r.opcode == OP_LCA) begin
                  rsp.result_node = hit;
               end else begin
                  rsp.path_length = root_dist_tab[r.node_a] + root_dist_tab[r.node_b]
                                    - (root_dist_tab[hit] << 1);
               end
            end
         end
      endcase
      return rsp;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic req_type make_req(input opcode_type op, input int a, input int b,
                                        input int k, input int w);
      req_type r;
      r.opcode      = op;
      r.node_a      = NODE_W'(a);
      r.node_b      = NODE_W'(b);
      r.step_count  = STEP_W'(k);
      r.edge_weight = WEIGHT_W'(w);
      return r;
   endfunction

   function automatic logic [NODE_W-1:0] pick_known_node();
      if ($urandom_range(99) < 90)
         return present_list[$urandom_range(present_list.size() - 1)];
      return NODE_W'($urandom_range(NODES - 1));
   endfunction

   function automatic req_type random_request();
      req_type           r;
      int                pick;
      int                reach;
      logic [NODE_W-1:0] cand;
      r.opcode      = opcode_type'($urandom_range(3));
      r.node_a      = NODE_W'($urandom_range(NODES - 1));
      r.node_b      = NODE_W'($urandom_range(NODES - 1));
      r.step_count  = STEP_W'($urandom_range(MAX_STEP));
      r.edge_weight = WEIGHT_W'($urandom_range(16'hFFFF));
      // A small share of pure noise; the rest grows and queries a real tree.
      if ($urandom_range(99) < 8) return r;
      pick = $urandom_range(99);
      if (pick < 30) begin
         r.opcode = OP_INSERT;
         if ($urandom_range(99) < 85) begin
            cand = NODE_W'($urandom_range(NODES - 1, 1));
            for (int t = 0; t < 16 && node_present[cand]; t++)
               cand = NODE_W'($urandom_range(NODES - 1, 1));
         end else begin
            cand = NODE_W'($urandom_range(NODES - 1));
         end
         r.node_a = cand;
         pick = $urandom_range(99);
         if (pick < 50)      r.node_b = last_inserted;
         else if (pick < 90) r.node_b = present_list[$urandom_range(present_list.size() - 1)];
      end else begin
         r.node_a = pick_known_node();
         r.node_b = pick_known_node();
         if (pick < 55) begin
            r.opcode = OP_KTH;
            if ($urandom_range(99) < 70) begin
               if (depth_tab[r.node_a] > MAX_STEP - 2) reach = MAX_STEP;
               else reach = int'(depth_tab[r.node_a]) + 2;
               r.step_count = STEP_W'($urandom_range(reach));
            end
         end else if (pick < 80) begin
            r.opcode = OP_LCA;
         end else begin
            r.opcode = OP_DIST;
         end
      end
      return r;
   endfunction

   // Sends one request beat and records the predicted response once accepted.
   // Called at a rising edge; valid stays high across back-to-back beats.
   task automatic send_req(input req_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      if (item.opcode == OP_INSERT && item.node_a != '0) begin
         if (!node_present[item.node_a]) begin
            node_present[item.node_a] = 1'b1;
            present_list.push_back(item.node_a);
         end
         last_inserted = item.node_a;
      end
      pending_rsp_q.push_back(apply_request(item));
   endtask

   // Holds the sender off until every response is back and the engine is quiet.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_mode(input logic mode);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      weighted = mode;
   endtask

   // ------------------------------------------------------------------------
   // Response checking
   // ------------------------------------------------------------------------
   task automatic check_response(input rsp_type got);
      rsp_type want;
      if (pending_rsp_q.size() == 0) begin
         $error("response beat with nothing outstanding: result_node %0d found %0d path_length %0d",
                got.result_node, got.found, got.path_length);
         fail_count++;
         return;
      end
      want = pending_rsp_q.pop_front();
      if (got.result_node !== want.result_node) begin
         $error("result_node expected %0d actual %0d", want.result_node, got.result_node);
         fail_count++;
      end
      if (got.found !== want.found) begin
         $error("found expected %0d actual %0d", want.found, got.found);
         fail_count++;
      end
      if (got.path_length !== want.path_length) begin
         $error("path_length expected %0d actual %0d", want.path_length, got.path_length);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_ready) check_response(rsp_data);
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_directed_unit();
      set_mode(1'b0);
      send_req(make_req(OP_INSERT, 0, 0, 0, 0));          // root insert is ignored
      send_req(make_req(OP_KTH, 0, 0, 0, 0));             // zero steps from root
      send_req(make_req(OP_KTH, 0, 0, 1, 0));             // climb past root
      send_req(make_req(OP_LCA, 0, 0, 0, 0));
      send_req(make_req(OP_LCA, 5, 7, 0, 0));             // neither node inserted
      send_req(make_req(OP_DIST, 5, 7, 0, 0));
      send_req(make_req(OP_INSERT, 1, 0, 0, 16'hFFFF));   // weight ignored in unit mode
      send_req(make_req(OP_INSERT, 2, 1, 0, 0));
      send_req(make_req(OP_INSERT, 1023, 2, 0, 16'hFFFF));
      send_req(make_req(OP_INSERT, 3, 1, 0, 16'h8000));
      send_req(make_req(OP_KTH, 1023, 0, 3, 0));
      send_req(make_req(OP_KTH, 1023, 0, 4, 0));
      send_req(make_req(OP_KTH, 1023, 0, MAX_STEP, 0));
      send_req(make_req(OP_LCA, 1023, 3, 0, 0));
      send_req(make_req(OP_DIST, 1023, 3, 0, 0));
      send_req(make_req(OP_INSERT, 4, 600, 0, 7));        // parent never inserted
      send_req(make_req(OP_LCA, 4, 1023, 0, 0));          // no common ancestor
   endtask

   task automatic test_directed_weighted();
      set_mode(1'b1);
      // Re-inserting node 1 heavier than its child makes the distance wrap.
      send_req(make_req(OP_INSERT, 1, 0, 0, 16'hFFFF));
      send_req(make_req(OP_DIST, 1, 2, 0, 0));
      send_req(make_req(OP_INSERT, 1022, 1023, 0, 16'hFFFF));
      send_req(make_req(OP_KTH, 1022, 0, 0, 0));
      send_req(make_req(OP_LCA, 2, 1022, 0, 0));
      send_req(make_req(OP_DIST, 1022, 3, 0, 0));
   endtask

   task automatic test_random_traffic(input int count, input logic mode,
                                      input int send_pct, input int recv_pct);
      set_mode(mode);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (count) send_req(random_request());
   endtask

   initial begin
      for (int n = 0; n < NODES; n++) begin
         for (int l = 0; l < LEVELS; l++) anc_tab[n][l] = '0;
         depth_tab[n]     = '0;
         root_dist_tab[n] = '0;
         node_present[n]  = 1'b0;
      end
      node_present[0] = 1'b1;
      present_list.push_back('0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 17;
      recv_idle_pct = 88;
      test_directed_unit();
      test_directed_weighted();
      test_random_traffic(530, 1'b1, 17, 88);
      test_random_traffic(530, 1'b0, 88, 17);
      test_random_traffic(540, 1'b1, 0, 0);

      drain_results();
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
